FILE: sv/qprm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qprm_pkg
// shared widths, register indexes and integrator limits for the rate mixer
// ----------------------------------------------------------------------------
package qprm_pkg;

	localparam int GYRO_W     = 12;
	localparam int GAIN_W     = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;
	localparam int MOTOR_W    = 8;

	// integrator state and its product with an integral gain
	localparam int INT_W     = 18;
	localparam int KI_PROD_W = INT_W + GAIN_W + 1;
	// signed quotient of that product by the integral divisor
	localparam int QUO_W     = KI_PROD_W - 6;
	localparam int KI_DIV    = 255;

	// per-axis integrator limits, the clamp is 256 times the limit
	localparam int PITCH_ILIMIT = 32;
	localparam int ROLL_ILIMIT  = 32;
	localparam int YAW_ILIMIT   = 32;

	localparam int THR_OFFSET = 200;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PITCH_KP   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PITCH_KI   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROLL_KP    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ROLL_KI    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_YAW_KP     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_YAW_KI     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_IDLE_SPEED = 3'd6;

	// load enables of the two divider stages
	typedef struct packed {
		logic s4;
		logic s5;
	} div_en_t;

endpackage

FILE: sv/qprm_div255.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qprm_div255
// two-stage signed divide by 255, truncating toward zero
// ----------------------------------------------------------------------------
module qprm_div255 (
	input  logic                                   clk,
	input  qprm_pkg::div_en_t                      en,
	input  logic signed [qprm_pkg::KI_PROD_W-1:0]  num,
	output logic signed [qprm_pkg::QUO_W-1:0]      quo
);

	localparam int MAG_W = qprm_pkg::KI_PROD_W;
	localparam int Q_W   = qprm_pkg::QUO_W - 1;

	logic [MAG_W-1:0]  mag;
	logic [MAG_W+16:0] recip;
	logic              neg_s4;
	logic [MAG_W-1:0]  mag_s4;
	logic [Q_W-1:0]    q0_s4;
	logic [MAG_W-1:0]  q0_ext;
	logic [MAG_W-1:0]  rem;
	logic [Q_W-1:0]    qmag;
	logic signed [qprm_pkg::QUO_W-1:0] quo_s5;

	// magnitude times 65793 / 2^24 undershoots by at most one
	always_comb begin
		mag   = num[MAG_W-1] ? MAG_W'(-num) : MAG_W'(num);
		recip = {1'b0, mag, 16'd0} + {9'd0, mag, 8'd0} + {17'd0, mag};
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			neg_s4 <= num[MAG_W-1];
			mag_s4 <= mag;
			q0_s4  <= recip[MAG_W+16:24];
		end
	end

	// one correction step from the remainder
	always_comb begin
		q0_ext = MAG_W'(q0_s4);
		rem    = mag_s4 - (q0_ext << 8) + q0_ext;
		qmag   = q0_s4 + Q_W'(rem >= MAG_W'(qprm_pkg::KI_DIV));
	end

	always_ff @(posedge clk) begin
		if (en.s5) begin
			quo_s5 <= neg_s4 ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
		end
	end

	assign quo = quo_s5;

endmodule

FILE: sv/quad_pi_rate_mixer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quad_pi_rate_mixer
// pi rate controller with plus-layout four-motor mixer, nine-stage pipeline
// ----------------------------------------------------------------------------
// channel   direction  handshake              payload
// input     in         in_valid / in_ready    gyro, accel, sticks, knob, flags
// output    out        out_valid / out_ready  front/left/right/rear motor
// config    in         cfg_wen                cfg_addr, cfg_wdata
//
// one beat per cycle sustained while out_ready stays high, results leave from the stage 9 register
// the integrators are the only feedback: they update as a beat leaves stage 1
// reset clears the gain registers, the integrators and all stage valids
// each stage holds only while full and its successor holds, so bubbles are
// squeezed out and input is taken while a finished result waits at the output
// ----------------------------------------------------------------------------
module quad_pi_rate_mixer (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// input channel
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [11:0]                     gyro_pitch_rate,
	input  logic signed [11:0]                     gyro_roll_rate,
	input  logic signed [11:0]                     gyro_yaw_rate,
	input  logic signed [11:0]                     accel_z_dev,
	input  logic signed [11:0]                     accel_y_dev,
	input  logic [11:0]                            throttle_stick,
	input  logic signed [11:0]                     pitch_stick,
	input  logic signed [11:0]                     roll_stick,
	input  logic signed [11:0]                     yaw_stick,
	input  logic signed [11:0]                     accel_gain_knob,
	input  logic                                   clear_integrals,
	input  logic                                   arm,
	// output channel
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [7:0]                             front_motor,
	output logic [7:0]                             left_motor,
	output logic [7:0]                             right_motor,
	output logic [7:0]                             rear_motor,
	// configuration
	input  logic                                   cfg_wen,
	input  logic [qprm_pkg::CFG_IDX_W-1:0]         cfg_addr,
	input  logic [qprm_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

	localparam int D_W = qprm_pkg::QUO_W + 2;
	localparam logic signed [qprm_pkg::INT_W-1:0] PITCH_IBOUND =
		qprm_pkg::INT_W'(256 * qprm_pkg::PITCH_ILIMIT);
	localparam logic signed [qprm_pkg::INT_W-1:0] ROLL_IBOUND =
		qprm_pkg::INT_W'(256 * qprm_pkg::ROLL_ILIMIT);
	localparam logic signed [qprm_pkg::INT_W-1:0] YAW_IBOUND =
		qprm_pkg::INT_W'(256 * qprm_pkg::YAW_ILIMIT);
	localparam logic signed [9:0] MOTOR_MAX = 10'sd255;

	// ------------------------------------------------------------------
	// stage payloads
	// ------------------------------------------------------------------
	typedef struct packed {
		logic signed [11:0] gyro_pitch_rate;
		logic signed [11:0] gyro_roll_rate;
		logic signed [11:0] gyro_yaw_rate;
		logic signed [11:0] accel_z_dev;
		logic signed [11:0] accel_y_dev;
		logic [11:0]        throttle_stick;
		logic signed [11:0] pitch_stick;
		logic signed [11:0] roll_stick;
		logic signed [11:0] yaw_stick;
		logic signed [11:0] accel_gain_knob;
		logic               clear_integrals;
		logic               arm;
	} s1_t;

	typedef struct packed {
		logic signed [20:0]                   p_pitch;
		logic signed [20:0]                   p_roll;
		logic signed [20:0]                   p_yaw;
		logic signed [20:0]                   a_pitch;
		logic signed [20:0]                   a_roll;
		logic signed [qprm_pkg::INT_W-1:0]    i_pitch;
		logic signed [qprm_pkg::INT_W-1:0]    i_roll;
		logic signed [qprm_pkg::INT_W-1:0]    i_yaw;
		logic signed [7:0]                    s_pitch;
		logic signed [7:0]                    s_roll;
		logic signed [7:0]                    s_yaw;
		logic [7:0]                           thr;
		logic                                 arm;
	} s2_t;

	// terms that ride alongside the divider
	typedef struct packed {
		logic signed [11:0] p_pitch;
		logic signed [11:0] p_roll;
		logic signed [11:0] p_yaw;
		logic signed [8:0]  a_pitch;
		logic signed [8:0]  a_roll;
		logic signed [7:0]  s_pitch;
		logic signed [7:0]  s_roll;
		logic signed [7:0]  s_yaw;
		logic [7:0]         thr;
		logic               arm;
	} side_t;

	typedef struct packed {
		logic signed [D_W-1:0] d_pitch;
		logic signed [D_W-1:0] d_roll;
		logic signed [D_W-1:0] d_yaw;
		logic [7:0]            thr;
		logic                  arm;
	} s6_t;

	typedef struct packed {
		logic [7:0]            front;
		logic [7:0]            left;
		logic [7:0]            right;
		logic [7:0]            rear;
		logic signed [D_W-1:0] d_yaw;
		logic                  arm;
	} s7_t;

	typedef struct packed {
		logic [7:0]        front;
		logic [7:0]        left;
		logic [7:0]        right;
		logic [7:0]        rear;
		logic signed [9:0] d_yaw;
		logic              arm;
	} s8_t;

	typedef struct packed {
		logic [7:0] front;
		logic [7:0] left;
		logic [7:0] right;
		logic [7:0] rear;
	} s9_t;

	// ------------------------------------------------------------------
	// helpers
	// ------------------------------------------------------------------
	// halve toward zero
	function automatic logic signed [11:0] half_trunc(input logic signed [12:0] x);
		logic signed [12:0] t;
		t = x + $signed({12'd0, x[12]});
		return t[12:1];
	endfunction

	// divide by 16 toward zero
	function automatic logic signed [7:0] div16(input logic signed [11:0] s);
		logic signed [12:0] t;
		t = {s[11], s} + (s[11] ? 13'sd15 : 13'sd0);
		return t[11:4];
	endfunction

	function automatic logic signed [qprm_pkg::INT_W-1:0] integ_next(
		input logic signed [qprm_pkg::INT_W-1:0] acc,
		input logic signed [11:0]                rate,
		input logic signed [qprm_pkg::INT_W-1:0] bound
	);
		logic signed [qprm_pkg::INT_W-1:0] sum;
		sum = acc + $signed({{(qprm_pkg::INT_W-12){rate[11]}}, rate});
		if (sum > bound)
			return bound;
		else if (sum < -bound)
			return -bound;
		else
			return sum;
	endfunction

	function automatic logic signed [9:0] max2(input logic signed [9:0] a,
		input logic signed [9:0] b);
		return (a > b) ? a : b;
	endfunction

	function automatic logic signed [9:0] min2(input logic signed [9:0] a,
		input logic signed [9:0] b);
		return (a < b) ? a : b;
	endfunction

	// clamp a wide correction into a 10-bit window that contains zero
	function automatic logic signed [9:0] clamp_corr(input logic signed [D_W-1:0] d,
		input logic signed [9:0] lo, input logic signed [9:0] hi);
		logic signed [D_W-1:0] lo_x;
		logic signed [D_W-1:0] hi_x;
		lo_x = $signed({{(D_W-10){lo[9]}}, lo});
		hi_x = $signed({{(D_W-10){hi[9]}}, hi});
		if (d < lo_x)
			return lo;
		else if (d > hi_x)
			return hi;
		else
			return d[9:0];
	endfunction

	// armed motors never drop below idle
	function automatic logic [7:0] motor_out(input logic signed [9:0] x,
		input logic [7:0] idle, input logic armed);
		if (!armed)
			return 8'd0;
		else if (x[7:0] < idle)
			return idle;
		else
			return x[7:0];
	endfunction

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	logic [7:0] pitch_kp_q, pitch_ki_q, roll_kp_q, roll_ki_q;
	logic [7:0] yaw_kp_q, yaw_ki_q, idle_speed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_kp_q   <= '0;
			pitch_ki_q   <= '0;
			roll_kp_q    <= '0;
			roll_ki_q    <= '0;
			yaw_kp_q     <= '0;
			yaw_ki_q     <= '0;
			idle_speed_q <= '0;
		end else if (cfg_wen) begin
			unique case (cfg_addr)
				qprm_pkg::CFG_PITCH_KP:   pitch_kp_q   <= cfg_wdata;
				qprm_pkg::CFG_PITCH_KI:   pitch_ki_q   <= cfg_wdata;
				qprm_pkg::CFG_ROLL_KP:    roll_kp_q    <= cfg_wdata;
				qprm_pkg::CFG_ROLL_KI:    roll_ki_q    <= cfg_wdata;
				qprm_pkg::CFG_YAW_KP:     yaw_kp_q     <= cfg_wdata;
				qprm_pkg::CFG_YAW_KI:     yaw_ki_q     <= cfg_wdata;
				qprm_pkg::CFG_IDLE_SPEED: idle_speed_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// stage valids and load enables
	// ------------------------------------------------------------------
	logic [9:1] vld_q;
	logic [9:1] en;

	// a stage loads when it is empty or its content moves on
	always_comb begin
		en[9] = !vld_q[9] || out_ready;
		en[8] = !vld_q[8] || en[9];
		en[7] = !vld_q[7] || en[8];
		en[6] = !vld_q[6] || en[7];
		en[5] = !vld_q[5] || en[6];
		en[4] = !vld_q[4] || en[5];
		en[3] = !vld_q[3] || en[4];
		en[2] = !vld_q[2] || en[3];
		en[1] = !vld_q[1] || en[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= (en & {vld_q[8:1], in_valid}) | (~en & vld_q);
		end
	end

	assign in_ready  = en[1];
	assign out_valid = vld_q[9];

	// ------------------------------------------------------------------
	// stage 1: input register
	// ------------------------------------------------------------------
	s1_t in_s1;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			in_s1.gyro_pitch_rate <= gyro_pitch_rate;
			in_s1.gyro_roll_rate  <= gyro_roll_rate;
			in_s1.gyro_yaw_rate   <= gyro_yaw_rate;
			in_s1.accel_z_dev     <= accel_z_dev;
			in_s1.accel_y_dev     <= accel_y_dev;
			in_s1.throttle_stick  <= throttle_stick;
			in_s1.pitch_stick     <= pitch_stick;
			in_s1.roll_stick      <= roll_stick;
			in_s1.yaw_stick       <= yaw_stick;
			in_s1.accel_gain_knob <= accel_gain_knob;
			in_s1.clear_integrals <= clear_integrals;
			in_s1.arm             <= arm;
		end
	end

	// ------------------------------------------------------------------
	// stage 1 -> 2: halved rates, integrators, p and accel products
	// ------------------------------------------------------------------
	logic signed [11:0] rate_pitch, rate_roll, rate_yaw;
	logic signed [qprm_pkg::INT_W-1:0] pitch_integral_q, roll_integral_q, yaw_integral_q;
	logic signed [qprm_pkg::INT_W-1:0] pitch_int_nxt, roll_int_nxt, yaw_int_nxt;
	logic [7:0]  accel_gain;
	logic [11:0] thr_off;
	logic [8:0]  thr_div;
	logic [7:0]  thr;
	s2_t         nxt_s2;
	s2_t         prod_s2;

	always_comb begin
		// roll and yaw are negated before halving
		rate_pitch = half_trunc({in_s1.gyro_pitch_rate[11], in_s1.gyro_pitch_rate});
		rate_roll  = half_trunc(-{in_s1.gyro_roll_rate[11], in_s1.gyro_roll_rate});
		rate_yaw   = half_trunc(-{in_s1.gyro_yaw_rate[11], in_s1.gyro_yaw_rate});

		if (in_s1.clear_integrals) begin
			pitch_int_nxt = '0;
			roll_int_nxt  = '0;
			yaw_int_nxt   = '0;
		end else begin
			pitch_int_nxt = integ_next(pitch_integral_q, rate_pitch, PITCH_IBOUND);
			roll_int_nxt  = integ_next(roll_integral_q, rate_roll, ROLL_IBOUND);
			yaw_int_nxt   = integ_next(yaw_integral_q, rate_yaw, YAW_IBOUND);
		end

		// knob clamped into an 8-bit accel gain
		if (in_s1.accel_gain_knob[11])
			accel_gain = 8'd0;
		else if (in_s1.accel_gain_knob > 12'sd255)
			accel_gain = 8'hFF;
		else
			accel_gain = in_s1.accel_gain_knob[7:0];

		// throttle below the offset truncates to zero
		thr_off = in_s1.throttle_stick - 12'(qprm_pkg::THR_OFFSET);
		thr_div = thr_off[11:3];
		if (in_s1.throttle_stick < 12'(qprm_pkg::THR_OFFSET))
			thr = 8'd0;
		else if (thr_div > 9'd255)
			thr = 8'hFF;
		else
			thr = thr_div[7:0];

		nxt_s2.p_pitch = rate_pitch * $signed({1'b0, pitch_kp_q});
		nxt_s2.p_roll  = rate_roll * $signed({1'b0, roll_kp_q});
		nxt_s2.p_yaw   = rate_yaw * $signed({1'b0, yaw_kp_q});
		nxt_s2.a_pitch = in_s1.accel_z_dev * $signed({1'b0, accel_gain});
		nxt_s2.a_roll  = in_s1.accel_y_dev * $signed({1'b0, accel_gain});
		nxt_s2.i_pitch = pitch_int_nxt;
		nxt_s2.i_roll  = roll_int_nxt;
		nxt_s2.i_yaw   = yaw_int_nxt;
		nxt_s2.s_pitch = div16(in_s1.pitch_stick);
		nxt_s2.s_roll  = div16(in_s1.roll_stick);
		nxt_s2.s_yaw   = div16(in_s1.yaw_stick);
		nxt_s2.thr     = thr;
		nxt_s2.arm     = in_s1.arm;
	end

	// integrators step once per beat, armed or not
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_integral_q <= '0;
			roll_integral_q  <= '0;
			yaw_integral_q   <= '0;
		end else if (en[2] && vld_q[1]) begin
			pitch_integral_q <= pitch_int_nxt;
			roll_integral_q  <= roll_int_nxt;
			yaw_integral_q   <= yaw_int_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (en[2])
			prod_s2 <= nxt_s2;
	end

	// ------------------------------------------------------------------
	// stage 2 -> 3: i products, p /512 and accel /4096 toward zero
	// ------------------------------------------------------------------
	logic signed [20:0] p_pitch_b, p_roll_b, p_yaw_b, a_pitch_b, a_roll_b;
	logic signed [qprm_pkg::KI_PROD_W-1:0] ip_pitch, ip_roll, ip_yaw;
	logic signed [qprm_pkg::KI_PROD_W-1:0] ip_pitch_s3, ip_roll_s3, ip_yaw_s3;
	side_t nxt_side;
	side_t side_s3, side_s4, side_s5;

	always_comb begin
		ip_pitch = prod_s2.i_pitch * $signed({1'b0, pitch_ki_q});
		ip_roll  = prod_s2.i_roll * $signed({1'b0, roll_ki_q});
		ip_yaw   = prod_s2.i_yaw * $signed({1'b0, yaw_ki_q});

		p_pitch_b = prod_s2.p_pitch + (prod_s2.p_pitch[20] ? 21'sd511 : 21'sd0);
		p_roll_b  = prod_s2.p_roll + (prod_s2.p_roll[20] ? 21'sd511 : 21'sd0);
		p_yaw_b   = prod_s2.p_yaw + (prod_s2.p_yaw[20] ? 21'sd511 : 21'sd0);
		a_pitch_b = prod_s2.a_pitch + (prod_s2.a_pitch[20] ? 21'sd4095 : 21'sd0);
		a_roll_b  = prod_s2.a_roll + (prod_s2.a_roll[20] ? 21'sd4095 : 21'sd0);

		nxt_side.p_pitch = p_pitch_b[20:9];
		nxt_side.p_roll  = p_roll_b[20:9];
		nxt_side.p_yaw   = p_yaw_b[20:9];
		nxt_side.a_pitch = a_pitch_b[20:12];
		nxt_side.a_roll  = a_roll_b[20:12];
		nxt_side.s_pitch = prod_s2.s_pitch;
		nxt_side.s_roll  = prod_s2.s_roll;
		nxt_side.s_yaw   = prod_s2.s_yaw;
		nxt_side.thr     = prod_s2.thr;
		nxt_side.arm     = prod_s2.arm;
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			ip_pitch_s3 <= ip_pitch;
			ip_roll_s3  <= ip_roll;
			ip_yaw_s3   <= ip_yaw;
			side_s3     <= nxt_side;
		end
	end

	// ------------------------------------------------------------------
	// stages 3 -> 5: integral terms divided by 255
	// ------------------------------------------------------------------
	qprm_pkg::div_en_t div_en;
	logic signed [qprm_pkg::QUO_W-1:0] iq_pitch, iq_roll, iq_yaw;

	assign div_en.s4 = en[4];
	assign div_en.s5 = en[5];

	qprm_div255 u_div_pitch (.clk(clk), .en(div_en), .num(ip_pitch_s3), .quo(iq_pitch));
	qprm_div255 u_div_roll  (.clk(clk), .en(div_en), .num(ip_roll_s3),  .quo(iq_roll));
	qprm_div255 u_div_yaw   (.clk(clk), .en(div_en), .num(ip_yaw_s3),   .quo(iq_yaw));

	always_ff @(posedge clk) begin
		if (en[4])
			side_s4 <= side_s3;
		if (en[5])
			side_s5 <= side_s4;
	end

	// ------------------------------------------------------------------
	// stage 5 -> 6: raw corrections (yaw has no accel term)
	// ------------------------------------------------------------------
	s6_t nxt_s6;
	s6_t corr_s6;

	always_comb begin
		nxt_s6.d_pitch = side_s5.p_pitch + iq_pitch + side_s5.a_pitch + side_s5.s_pitch;
		nxt_s6.d_roll  = side_s5.p_roll + iq_roll + side_s5.a_roll + side_s5.s_roll;
		nxt_s6.d_yaw   = side_s5.p_yaw + iq_yaw + side_s5.s_yaw;
		nxt_s6.thr     = side_s5.thr;
		nxt_s6.arm     = side_s5.arm;
	end

	always_ff @(posedge clk) begin
		if (en[6])
			corr_s6 <= nxt_s6;
	end

	// ------------------------------------------------------------------
	// stage 6 -> 7: pitch and roll clamped and mixed from throttle
	// ------------------------------------------------------------------
	logic signed [9:0] thr_x, lo_pr, hi_pr, d_pitch_c, d_roll_c;
	logic signed [9:0] f_pr, b_pr, l_pr, r_pr;
	s7_t nxt_s7;
	s7_t mix_s7;

	always_comb begin
		// all four motors start at throttle, so both axes share one window
		thr_x     = $signed({2'b00, corr_s6.thr});
		lo_pr     = max2(thr_x - MOTOR_MAX, -thr_x);
		hi_pr     = min2(thr_x, MOTOR_MAX - thr_x);
		d_pitch_c = clamp_corr(corr_s6.d_pitch, lo_pr, hi_pr);
		d_roll_c  = clamp_corr(corr_s6.d_roll, lo_pr, hi_pr);
		f_pr      = thr_x - d_pitch_c;
		b_pr      = thr_x + d_pitch_c;
		l_pr      = thr_x - d_roll_c;
		r_pr      = thr_x + d_roll_c;

		nxt_s7.front = f_pr[7:0];
		nxt_s7.rear  = b_pr[7:0];
		nxt_s7.left  = l_pr[7:0];
		nxt_s7.right = r_pr[7:0];
		nxt_s7.d_yaw = corr_s6.d_yaw;
		nxt_s7.arm   = corr_s6.arm;
	end

	always_ff @(posedge clk) begin
		if (en[7])
			mix_s7 <= nxt_s7;
	end

	// ------------------------------------------------------------------
	// stage 7 -> 8: yaw window from all four motors
	// ------------------------------------------------------------------
	logic signed [9:0] f_x, l_x, r_x, b_x, lo_y, hi_y;
	s8_t nxt_s8;
	s8_t yaw_s8;

	always_comb begin
		f_x  = $signed({2'b00, mix_s7.front});
		l_x  = $signed({2'b00, mix_s7.left});
		r_x  = $signed({2'b00, mix_s7.right});
		b_x  = $signed({2'b00, mix_s7.rear});
		// sequential clamps to windows holding zero equal one clamp to their overlap
		lo_y = max2(max2(l_x - MOTOR_MAX, r_x - MOTOR_MAX), max2(-f_x, -b_x));
		hi_y = min2(min2(l_x, r_x), min2(MOTOR_MAX - f_x, MOTOR_MAX - b_x));

		nxt_s8.front = mix_s7.front;
		nxt_s8.left  = mix_s7.left;
		nxt_s8.right = mix_s7.right;
		nxt_s8.rear  = mix_s7.rear;
		nxt_s8.d_yaw = clamp_corr(mix_s7.d_yaw, lo_y, hi_y);
		nxt_s8.arm   = mix_s7.arm;
	end

	always_ff @(posedge clk) begin
		if (en[8])
			yaw_s8 <= nxt_s8;
	end

	// ------------------------------------------------------------------
	// stage 8 -> 9: yaw mix, idle floor, disarm, output register
	// ------------------------------------------------------------------
	logic signed [9:0] f_y, l_y, r_y, b_y;
	s9_t nxt_s9;
	s9_t out_s9;

	always_comb begin
		f_y = $signed({2'b00, yaw_s8.front}) + yaw_s8.d_yaw;
		b_y = $signed({2'b00, yaw_s8.rear}) + yaw_s8.d_yaw;
		l_y = $signed({2'b00, yaw_s8.left}) - yaw_s8.d_yaw;
		r_y = $signed({2'b00, yaw_s8.right}) - yaw_s8.d_yaw;

		nxt_s9.front = motor_out(f_y, idle_speed_q, yaw_s8.arm);
		nxt_s9.left  = motor_out(l_y, idle_speed_q, yaw_s8.arm);
		nxt_s9.right = motor_out(r_y, idle_speed_q, yaw_s8.arm);
		nxt_s9.rear  = motor_out(b_y, idle_speed_q, yaw_s8.arm);
	end

	always_ff @(posedge clk) begin
		if (en[9])
			out_s9 <= nxt_s9;
	end

	assign front_motor = out_s9.front;
	assign left_motor  = out_s9.left;
	assign right_motor = out_s9.right;
	assign rear_motor  = out_s9.rear;

endmodule

FILE: verif/quad_pi_rate_mixer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quad_pi_rate_mixer_tb
// self-checking bench for the pi rate controller and plus-layout motor mixer
// ----------------------------------------------------------------------------
// a scoreboard keeps its own integrators and gain registers, predicts the four
// motor commands for every input beat taken and checks the output beats in
// order. a short directed set hits the field extremes, disarm, integrator
// clear and the correction clamps, then random phases run under max, zero and
// random gains with random gaps on both sides and two long output stalls
// ----------------------------------------------------------------------------
module quad_pi_rate_mixer_tb;

	localparam int CLIP_RANGE     = 256;
	localparam int DRAIN_CYCLES   = 12;
	localparam int CYCLE_LIMIT    = 300000;
	localparam int PHASE_BEATS    = 155;
	localparam int LONG_HOLD      = 120;
	localparam int HOLD_FIRST     = 60;
	localparam int HOLD_SECOND    = 520;
	localparam int MAX_PRINTS     = 100;

	// register write order, position i is register index i
	localparam logic [qprm_pkg::CFG_IDX_W-1:0] REG_INDEX [7] = '{
		qprm_pkg::CFG_PITCH_KP, qprm_pkg::CFG_PITCH_KI, qprm_pkg::CFG_ROLL_KP,
		qprm_pkg::CFG_ROLL_KI, qprm_pkg::CFG_YAW_KP, qprm_pkg::CFG_YAW_KI,
		qprm_pkg::CFG_IDLE_SPEED
	};
	localparam logic [7:0] MID_GAINS [7] = '{8'd96, 8'd40, 8'd120, 8'd60, 8'd80, 8'd30, 8'd12};

	typedef enum int {GAINS_MID, GAINS_MAX, GAINS_ZERO, GAINS_RANDOM} gain_mode_t;

	typedef struct {
		logic signed [11:0] gyro_pitch_rate;
		logic signed [11:0] gyro_roll_rate;
		logic signed [11:0] gyro_yaw_rate;
		logic signed [11:0] accel_z_dev;
		logic signed [11:0] accel_y_dev;
		logic [11:0]        throttle_stick;
		logic signed [11:0] pitch_stick;
		logic signed [11:0] roll_stick;
		logic signed [11:0] yaw_stick;
		logic signed [11:0] accel_gain_knob;
		logic               clear_integrals;
		logic               arm;
	} sample_t;

	typedef struct packed {
		logic [7:0] front;
		logic [7:0] left;
		logic [7:0] right;
		logic [7:0] rear;
	} motors_t;

	// ------------------------------------------------------------------------
	// scoreboard: own integrators and gains, queue of motor commands due
	// ------------------------------------------------------------------------
	class motor_scoreboard;
		int         pitch_acc, roll_acc, yaw_acc;
		logic [7:0] gains [7];
		motors_t    motor_cmds_due [$];
		int         beats_taken, disarmed_beats, cleared_beats, cmds_checked, mismatches;

		function new();
			pitch_acc = 0;
			roll_acc  = 0;
			yaw_acc   = 0;
			foreach (gains[i]) gains[i] = '0;
		endfunction

		static function int clip(int x, int lo, int hi);
			return (x < lo) ? lo : ((x > hi) ? hi : x);
		endfunction

		function void set_gain(logic [qprm_pkg::CFG_IDX_W-1:0] idx, logic [7:0] val);
			gains[idx] = val;
		endfunction

		function int pending();
			return motor_cmds_due.size();
		endfunction

		// integrators first, then the mix from throttle and the three corrections
		function motors_t mix_motors(sample_t s);
			int      pr, rr, yr, gain, thr, front, left, right, rear, d, idle;
			motors_t m;
			pr   = int'(s.gyro_pitch_rate) / 2;
			rr   = -int'(s.gyro_roll_rate) / 2;
			yr   = -int'(s.gyro_yaw_rate) / 2;
			gain = clip(int'(s.accel_gain_knob), 0, 255);
			thr  = clip((int'(s.throttle_stick) - qprm_pkg::THR_OFFSET) / 8, 0, 255);
			if (s.clear_integrals) begin
				pitch_acc = 0;
				roll_acc  = 0;
				yaw_acc   = 0;
			end else begin
				pitch_acc = clip(pitch_acc + pr, -CLIP_RANGE * qprm_pkg::PITCH_ILIMIT,
					CLIP_RANGE * qprm_pkg::PITCH_ILIMIT);
				roll_acc  = clip(roll_acc + rr, -CLIP_RANGE * qprm_pkg::ROLL_ILIMIT,
					CLIP_RANGE * qprm_pkg::ROLL_ILIMIT);
				yaw_acc   = clip(yaw_acc + yr, -CLIP_RANGE * qprm_pkg::YAW_ILIMIT,
					CLIP_RANGE * qprm_pkg::YAW_ILIMIT);
			end
			m = '0;
			if (!s.arm)
				return m;
			front = thr;
			left  = thr;
			right = thr;
			rear  = thr;
			// pitch moves front against rear
			d = (pr * int'(gains[qprm_pkg::CFG_PITCH_KP])) / 512
				+ (pitch_acc * int'(gains[qprm_pkg::CFG_PITCH_KI])) / qprm_pkg::KI_DIV
				+ (int'(s.accel_z_dev) * gain) / 4096 + int'(s.pitch_stick) / 16;
			d = clip(d, front - 255, front);
			d = clip(d, -rear, 255 - rear);
			front -= d;
			rear  += d;
			// roll moves left against right
			d = (rr * int'(gains[qprm_pkg::CFG_ROLL_KP])) / 512
				+ (roll_acc * int'(gains[qprm_pkg::CFG_ROLL_KI])) / qprm_pkg::KI_DIV
				+ (int'(s.accel_y_dev) * gain) / 4096 + int'(s.roll_stick) / 16;
			d = clip(d, left - 255, left);
			d = clip(d, -right, 255 - right);
			left  -= d;
			right += d;
			// yaw moves the side pair against the front/rear pair
			d = (yr * int'(gains[qprm_pkg::CFG_YAW_KP])) / 512
				+ (yaw_acc * int'(gains[qprm_pkg::CFG_YAW_KI])) / qprm_pkg::KI_DIV
				+ int'(s.yaw_stick) / 16;
			d = clip(d, left - 255, left);
			d = clip(d, right - 255, right);
			d = clip(d, -front, 255 - front);
			d = clip(d, -rear, 255 - rear);
			left  -= d;
			right -= d;
			front += d;
			rear  += d;
			idle    = int'(gains[qprm_pkg::CFG_IDLE_SPEED]);
			m.front = 8'(clip(front, idle, 255));
			m.left  = 8'(clip(left, idle, 255));
			m.right = 8'(clip(right, idle, 255));
			m.rear  = 8'(clip(rear, idle, 255));
			return m;
		endfunction

		function void note_input(sample_t s);
			beats_taken++;
			if (!s.arm)
				disarmed_beats++;
			if (s.clear_integrals)
				cleared_beats++;
			motor_cmds_due.push_back(mix_motors(s));
		endfunction

		task report(string what, logic [7:0] got, logic [7:0] want);
			mismatches++;
			if (mismatches <= MAX_PRINTS)
				$display("mismatch at motor command %0d: %s got %0d expected %0d",
					cmds_checked, what, got, want);
		endtask

		task check_result(motors_t got);
			motors_t want;
			if (motor_cmds_due.size() == 0) begin
				report("unexpected beat", got.front, 8'd0);
				return;
			end
			want = motor_cmds_due.pop_front();
			if (got.front !== want.front)
				report("front_motor", got.front, want.front);
			if (got.left !== want.left)
				report("left_motor", got.left, want.left);
			if (got.right !== want.right)
				report("right_motor", got.right, want.right);
			if (got.rear !== want.rear)
				report("rear_motor", got.rear, want.rear);
			cmds_checked++;
		endtask
	endclass

	// ------------------------------------------------------------------------
	// dut signals, all inputs known from time zero
	// ------------------------------------------------------------------------
	logic                            clk             = 1'b0;
	logic                            arst_n          = 1'b0;
	logic                            in_valid        = 1'b0;
	logic                            in_ready;
	logic signed [11:0]              gyro_pitch_rate = '0;
	logic signed [11:0]              gyro_roll_rate  = '0;
	logic signed [11:0]              gyro_yaw_rate   = '0;
	logic signed [11:0]              accel_z_dev     = '0;
	logic signed [11:0]              accel_y_dev     = '0;
	logic [11:0]                     throttle_stick  = '0;
	logic signed [11:0]              pitch_stick     = '0;
	logic signed [11:0]              roll_stick      = '0;
	logic signed [11:0]              yaw_stick       = '0;
	logic signed [11:0]              accel_gain_knob = '0;
	logic                            clear_integrals = 1'b0;
	logic                            arm             = 1'b0;
	logic                            out_valid;
	logic                            out_ready       = 1'b0;
	logic [7:0]                      front_motor;
	logic [7:0]                      left_motor;
	logic [7:0]                      right_motor;
	logic [7:0]                      rear_motor;
	logic                            cfg_wen         = 1'b0;
	logic [qprm_pkg::CFG_IDX_W-1:0]  cfg_addr        = '0;
	logic [qprm_pkg::CFG_DATA_W-1:0] cfg_wdata       = '0;

	motor_scoreboard sb;
	bit              rx_holding = 1'b0;  // receiver in a long stall, sender runs flat out
	bit              tx_burst   = 1'b0;
	bit              rx_burst   = 1'b0;
	int              gain_phases = 0;
	int              gyro_bias [3];      // -1, 0 or +1 per axis, drives the integrators

	quad_pi_rate_mixer uut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// hard stop in case the handshakes lock up
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("[FAIL] regression broken");
		$finish;
	end

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------
	function automatic logic [11:0] any12();
		return 12'($urandom);
	endfunction

	// gyro rate: mostly in range, biased runs push the integrators to their clamps
	function automatic logic [11:0] pick_rate(int axis);
		if ($urandom_range(0, 19) == 0)
			return any12();
		if (gyro_bias[axis] != 0)
			return 12'(gyro_bias[axis] * int'($urandom_range(256, 1024)));
		return 12'(int'($urandom_range(0, 2048)) - 1024);
	endfunction

	function automatic logic [11:0] pick_stick();
		if ($urandom_range(0, 4) == 0)
			return any12();
		return 12'(int'($urandom_range(0, 1023)) - 512);
	endfunction

	function automatic sample_t random_sample();
		sample_t s;
		s.gyro_pitch_rate = pick_rate(0);
		s.gyro_roll_rate  = pick_rate(1);
		s.gyro_yaw_rate   = pick_rate(2);
		s.accel_z_dev     = ($urandom_range(0, 9) == 0) ? any12()
			: 12'(int'($urandom_range(0, 2048)) - 1024);
		s.accel_y_dev     = ($urandom_range(0, 9) == 0) ? any12()
			: 12'(int'($urandom_range(0, 2048)) - 1024);
		s.throttle_stick  = ($urandom_range(0, 9) == 0) ? any12()
			: 12'($urandom_range(qprm_pkg::THR_OFFSET, 2300));
		s.pitch_stick     = pick_stick();
		s.roll_stick      = pick_stick();
		s.yaw_stick       = pick_stick();
		s.accel_gain_knob = ($urandom_range(0, 2) == 0) ? any12() : 12'($urandom_range(0, 255));
		s.clear_integrals = ($urandom_range(0, 24) == 0);
		s.arm             = ($urandom_range(0, 9) != 0);
		return s;
	endfunction

	// extremes, disarm, clear, truncation and clamp corners
	function automatic sample_t directed_sample(int k);
		sample_t s;
		s = '{default: '0};
		s.arm            = 1'b1;
		s.throttle_stick = 12'd1224;  // throttle 128
		case (k)
			0: s.throttle_stick = 12'd0;
			1: begin
				s.arm             = 1'b0;
				s.gyro_pitch_rate = 12'sd1000;
				s.pitch_stick     = 12'sd2047;
				s.throttle_stick  = 12'd4095;
			end
			2: s.throttle_stick = 12'd4095;
			3: s.gyro_pitch_rate = 12'sd1024;
			4: begin
				s.gyro_pitch_rate = -12'sd1024;
				s.gyro_roll_rate  = 12'sd1024;
				s.gyro_yaw_rate   = -12'sd1024;
			end
			5: begin
				s.gyro_pitch_rate = -12'sd1;
				s.gyro_roll_rate  = -12'sd1;
				s.gyro_yaw_rate   = -12'sd1;
			end
			6: begin
				s.gyro_pitch_rate = 12'sd1;
				s.gyro_roll_rate  = 12'sd1;
				s.gyro_yaw_rate   = 12'sd1;
			end
			7: begin
				s.gyro_pitch_rate = 12'sh7FF;
				s.gyro_roll_rate  = 12'sh7FF;
				s.gyro_yaw_rate   = 12'sh7FF;
				s.accel_z_dev     = 12'sh7FF;
				s.accel_y_dev     = 12'sh7FF;
				s.accel_gain_knob = 12'sd200;
			end
			8: begin
				s.gyro_pitch_rate = 12'sh800;
				s.gyro_roll_rate  = 12'sh800;
				s.gyro_yaw_rate   = 12'sh800;
				s.accel_z_dev     = 12'sh800;
				s.accel_y_dev     = 12'sh800;
				s.accel_gain_knob = 12'sh7FF;
			end
			9: begin
				s.accel_z_dev     = 12'sd1024;
				s.accel_y_dev     = -12'sd1024;
				s.accel_gain_knob = 12'sh800;
			end
			10: begin
				s.pitch_stick = 12'sh7FF;
				s.roll_stick  = 12'sh7FF;
				s.yaw_stick   = 12'sh7FF;
			end
			11: begin
				s.pitch_stick = 12'sh800;
				s.roll_stick  = 12'sh800;
				s.yaw_stick   = 12'sh800;
			end
			12: begin
				s.pitch_stick = -12'sd15;
				s.roll_stick  = 12'sd15;
				s.yaw_stick   = -12'sd17;
			end
			13: begin
				s.clear_integrals = 1'b1;
				s.gyro_pitch_rate = 12'sd700;
			end
			14: begin
				s.clear_integrals = 1'b1;
				s.arm             = 1'b0;
			end
			15: s.throttle_stick = 12'd201;
			16: s.throttle_stick = 12'd199;
			17: s.throttle_stick = 12'd2240;
			18: s.throttle_stick = 12'd2248;
			19: begin
				s.throttle_stick = 12'd4095;
				s.pitch_stick    = 12'sh7FF;
				s.yaw_stick      = 12'sh800;
			end
			20: begin
				s.throttle_stick = 12'd208;
				s.roll_stick     = 12'sh800;
				s.yaw_stick      = 12'sh7FF;
			end
			21: begin
				s.gyro_pitch_rate = 12'shFFF;
				s.gyro_roll_rate  = 12'shFFF;
				s.gyro_yaw_rate   = 12'shFFF;
				s.accel_z_dev     = 12'shFFF;
				s.accel_y_dev     = 12'shFFF;
				s.throttle_stick  = 12'hFFF;
				s.pitch_stick     = 12'shFFF;
				s.roll_stick      = 12'shFFF;
				s.yaw_stick       = 12'shFFF;
				s.accel_gain_knob = 12'shFFF;
			end
			default: s.gyro_yaw_rate = 12'sd512;
		endcase
		return s;
	endfunction

	// one input beat: random gap, then hold valid until in_ready
	task automatic send_beat(sample_t s);
		int gap;
		gap = (rx_holding || tx_burst) ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		gyro_pitch_rate <= s.gyro_pitch_rate;
		gyro_roll_rate  <= s.gyro_roll_rate;
		gyro_yaw_rate   <= s.gyro_yaw_rate;
		accel_z_dev     <= s.accel_z_dev;
		accel_y_dev     <= s.accel_y_dev;
		throttle_stick  <= s.throttle_stick;
		pitch_stick     <= s.pitch_stick;
		roll_stick      <= s.roll_stick;
		yaw_stick       <= s.yaw_stick;
		accel_gain_knob <= s.accel_gain_knob;
		clear_integrals <= s.clear_integrals;
		arm             <= s.arm;
		in_valid        <= 1'b1;
		do @(posedge clk); while (!in_ready);
		sb.note_input(s);
	endtask

	// close the input and let the pipeline empty out
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// write all seven registers back to back, only while the pipeline is empty
	task automatic load_gains(gain_mode_t mode);
		logic [7:0] val;
		for (int i = 0; i < 7; i++) begin
			case (mode)
				GAINS_MID:  val = MID_GAINS[i];
				GAINS_MAX:  val = 8'hFF;
				GAINS_ZERO: val = 8'h00;
				default:    val = 8'($urandom_range(0, 255));
			endcase
			cfg_wen   <= 1'b1;
			cfg_addr  <= REG_INDEX[i];
			cfg_wdata <= val;
			@(posedge clk);
			sb.set_gain(REG_INDEX[i], val);
		end
		cfg_wen <= 1'b0;
		gain_phases++;
	endtask

	// ------------------------------------------------------------------------
	// output side: random stalls, two long holds that back the pipeline up
	// ------------------------------------------------------------------------
	initial begin
		int gap;
		int got;
		got = 0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (got == HOLD_FIRST || got == HOLD_SECOND) begin
				// long hold: the sender keeps offering so in_ready must drop
				rx_holding = 1'b1;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				rx_holding = 1'b0;
			end else begin
				gap = rx_burst ? 0 : $urandom_range(0, 14);
				if (gap > 0) begin
					out_ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			sb.check_result('{front_motor, left_motor, right_motor, rear_motor});
			got++;
			// switch between stalling and back-to-back stretches now and then
			if (got % 37 == 0)
				rx_burst = ($urandom_range(0, 3) == 0);
		end
	end

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	initial begin
		gain_mode_t plan [6];
		sb = new();
		plan = '{GAINS_MAX, GAINS_ZERO, GAINS_RANDOM, GAINS_RANDOM, GAINS_RANDOM,
			GAINS_RANDOM};
		foreach (gyro_bias[a]) gyro_bias[a] = 0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed set under moderate gains
		load_gains(GAINS_MID);
		for (int k = 0; k < 23; k++)
			send_beat(directed_sample(k));
		drain();

		// random phases, each under its own gain setting
		foreach (plan[p]) begin
			load_gains(plan[p]);
			for (int n = 0; n < PHASE_BEATS; n++) begin
				if (n % 40 == 0)
					foreach (gyro_bias[a]) gyro_bias[a] = int'($urandom_range(0, 2)) - 1;
				if (n % 32 == 0)
					tx_burst = ($urandom_range(0, 3) == 0);
				send_beat(random_sample());
			end
			drain();
		end

		$display("covered %0d input beats (%0d disarmed, %0d integrator clears)",
			sb.beats_taken, sb.disarmed_beats, sb.cleared_beats);
		$display("over %0d gain settings, checked %0d motor command beats, %0d mismatches",
			gain_phases, sb.cmds_checked, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
